// ===== sv/stu_pkg.sv =====
`default_nettype none
package stu_pkg;

  localparam int CW = 16;
  localparam int ZW = 15;
  localparam int IW = 8;
  localparam int PW = 12;
  localparam int SPEED = 4;
  localparam int ROT_SHIFT = 6;
  localparam int ROT_STEPS = 2;
  localparam int DIV_STAGES = CW;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CLOCKWISE = 2'd2;

  typedef struct packed {
    logic [PW-1:0] width;
    logic [PW-1:0] height;
    logic          clockwise;
  } cfg_t;

  typedef struct packed {
    logic [IW-1:0]        idx;
    logic                 oob;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } job_t;

  typedef struct packed {
    logic                 en;
    logic [IW-1:0]        idx;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
  } wb_t;

endpackage
`default_nettype wire

// ===== sv/starfield_star_update.sv =====
`default_nettype none
// Updates one star of a 256-entry star store per transfer and returns one pixel per transfer,
// at one item per cycle while the output is not held off, through the 16-stage pipelined
// divider that projects x and y over depth. An item that names a star still in flight waits
// until that star's update is written back. The store reads as zero after reset through
// per-entry valid bits; no clearing pass is needed.
module starfield_star_update #(
  parameter int NUM_STARS = 256,
  parameter int MAX_DEPTH = 500
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // star_index, fresh_x, fresh_y, fresh_depth, spare_x, spare_y
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pixel_x, pixel_y
  output logic [23:0]      out_tdata,
  // visible
  output logic             out_tuser
);

  stu_pkg::cfg_t cfg_r;
  stu_pkg::job_t job_f, job_b;
  stu_pkg::wb_t  wb;
  logic          f_valid, f_ready, b_valid, b_ready;
  logic [$bits(stu_pkg::job_t)-1:0] q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width <= 12'd640;
      cfg_r.height <= 12'd480;
      cfg_r.clockwise <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        stu_pkg::CFG_WIDTH: cfg_r.width <= cfg_wdata;
        stu_pkg::CFG_HEIGHT: cfg_r.height <= cfg_wdata;
        stu_pkg::CFG_CLOCKWISE: cfg_r.clockwise <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  stu_front #(.NUM_STARS(NUM_STARS), .MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_idx(in_tdata[7:0]), .in_fx(in_tdata[23:8]), .in_fy(in_tdata[39:24]),
    .in_fd(in_tdata[48:40]), .in_sx(in_tdata[64:49]), .in_sy(in_tdata[80:65]),
    .job(job_f), .job_valid(f_valid), .job_ready(f_ready), .wb(wb)
  );

  stu_fifo #(.W($bits(stu_pkg::job_t))) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_data(job_f), .push_valid(f_valid), .push_ready(f_ready),
    .pop_data(q_out), .pop_valid(b_valid), .pop_ready(b_ready)
  );

  assign job_b = q_out;

  stu_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .job(job_b), .job_valid(b_valid), .job_ready(b_ready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .pixel_x(out_tdata[11:0]), .pixel_y(out_tdata[23:12]), .visible(out_tuser),
    .wb(wb)
  );

endmodule
`default_nettype wire

// ===== sv/stu_fifo.sv =====
`default_nettype none
module stu_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [W-1:0] push_data,
  input  wire logic         push_valid,
  output logic              push_ready,
  output logic [W-1:0]      pop_data,
  output logic              pop_valid,
  input  wire logic         pop_ready
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, rptr_r;
  logic [1:0]   count_r;
  logic         push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data = mem_r[rptr_r];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== sv/stu_front.sv =====
`default_nettype none
module stu_front #(
  parameter int NUM_STARS = 256,
  parameter int MAX_DEPTH = 500
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire stu_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [stu_pkg::IW-1:0]       in_idx,
  input  wire logic signed [stu_pkg::CW-1:0] in_fx,
  input  wire logic signed [stu_pkg::CW-1:0] in_fy,
  input  wire logic [8:0]                   in_fd,
  input  wire logic signed [stu_pkg::CW-1:0] in_sx,
  input  wire logic signed [stu_pkg::CW-1:0] in_sy,
  output stu_pkg::job_t                     job,
  output logic                              job_valid,
  input  wire logic                         job_ready,
  input  wire stu_pkg::wb_t                 wb
);

  localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

  logic signed [stu_pkg::CW-1:0] mem_x [NUM_STARS];
  logic signed [stu_pkg::CW-1:0] mem_y [NUM_STARS];
  logic [stu_pkg::ZW-1:0]        mem_z [NUM_STARS];
  logic [NUM_STARS-1:0]          vld_r, busy_r;

  logic [AW-1:0] addr_in, addr_wb;
  logic          oob_in, busy_hit, acc;

  logic                          f1_v_r, ok_r, oob_r;
  logic [stu_pkg::IW-1:0]        idx_r;
  logic signed [stu_pkg::CW-1:0] fx_r, fy_r, sx_r, sy_r, rdx_r, rdy_r;
  logic [8:0]                    fd_r;
  logic [stu_pkg::ZW-1:0]        rdz_r;

  logic signed [stu_pkg::CW-1:0] x0, y0, xo, yo;
  logic [stu_pkg::ZW-1:0]        z0, zo, fdc;
  logic signed [stu_pkg::ZW+1:0] zt;
  logic [2*stu_pkg::CW-1:0]      rv;

  function automatic logic [2*stu_pkg::CW-1:0] rot(input logic signed [stu_pkg::CW-1:0] x,
                                                    input logic signed [stu_pkg::CW-1:0] y,
                                                    input logic cw);
    logic signed [stu_pkg::CW-1:0] nx, ny;
    if (!cw) begin
      nx = x - (y >>> stu_pkg::ROT_SHIFT);
      ny = y + (nx >>> stu_pkg::ROT_SHIFT);
    end else begin
      nx = x + (y >>> stu_pkg::ROT_SHIFT);
      ny = y - (nx >>> stu_pkg::ROT_SHIFT);
    end
    return {nx, ny};
  endfunction

  assign addr_in = AW'(in_idx);
  assign addr_wb = AW'(wb.idx);
  assign oob_in = (32'(in_idx) >= NUM_STARS);
  assign busy_hit = !oob_in && busy_r[addr_in];
  assign in_ready = (!f1_v_r || job_ready) && !busy_hit;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem_x[addr_wb] <= wb.x;
      mem_y[addr_wb] <= wb.y;
      mem_z[addr_wb] <= wb.z;
    end
    if (acc) begin
      rdx_r <= mem_x[addr_in];
      rdy_r <= mem_y[addr_in];
      rdz_r <= mem_z[addr_in];
      idx_r <= in_idx;
      oob_r <= oob_in;
      fx_r <= in_fx;
      fy_r <= in_fy;
      fd_r <= in_fd;
      sx_r <= in_sx;
      sy_r <= in_sy;
    end
    if (!rst_n) begin
      vld_r <= '0;
      busy_r <= '0;
      f1_v_r <= 1'b0;
      ok_r <= 1'b0;
    end else begin
      if (acc) begin
        ok_r <= vld_r[addr_in];
        f1_v_r <= 1'b1;
      end else if (job_ready) begin
        f1_v_r <= 1'b0;
      end
      if (wb.en) begin
        vld_r[addr_wb] <= 1'b1;
        busy_r[addr_wb] <= 1'b0;
      end
      if (acc && !oob_in) begin
        busy_r[addr_in] <= 1'b1;
      end
    end
  end

  always_comb begin
    x0 = ok_r ? rdx_r : '0;
    y0 = ok_r ? rdy_r : '0;
    z0 = ok_r ? rdz_r : '0;
    zt = $signed({2'b00, z0}) - (stu_pkg::ZW+2)'(stu_pkg::SPEED);
    if (fd_r == 9'd0) begin
      fdc = stu_pkg::ZW'(1);
    end else if (32'(fd_r) > MAX_DEPTH) begin
      fdc = stu_pkg::ZW'(MAX_DEPTH);
    end else begin
      fdc = stu_pkg::ZW'(fd_r);
    end
    rv = {x0, y0};
    for (int k = 0; k < stu_pkg::ROT_STEPS; k++) begin
      rv = rot(rv[2*stu_pkg::CW-1:stu_pkg::CW], rv[stu_pkg::CW-1:0], cfg.clockwise);
    end
    if (zt <= 0) begin
      xo = fx_r;
      yo = fy_r;
      zo = (x0 != 0) ? stu_pkg::ZW'(MAX_DEPTH) : fdc;
    end else begin
      xo = rv[2*stu_pkg::CW-1:stu_pkg::CW];
      yo = rv[stu_pkg::CW-1:0];
      zo = zt[stu_pkg::ZW-1:0];
    end
    job.idx = idx_r;
    job.oob = oob_r;
    job.x = xo;
    job.y = yo;
    job.z = zo;
    job.sx = sx_r;
    job.sy = sy_r;
  end

  assign job_valid = f1_v_r;

`ifndef NO_ASSERTIONS
  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wb.en |-> busy_r[addr_wb]) else $error("write-back to a star not in flight");
  a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !oob_in |=> busy_r[$past(addr_in)]) else $error("accepted star not marked busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f1_v_r && !job_ready |=> f1_v_r && $stable(idx_r)) else $error("front stage lost an item");
`endif

endmodule
`default_nettype wire

// ===== sv/stu_back.sv =====
`default_nettype none
module stu_back #(
  parameter int MAX_DEPTH = 500
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire stu_pkg::cfg_t          cfg,
  input  wire stu_pkg::job_t          job,
  input  wire logic                   job_valid,
  output logic                        job_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [stu_pkg::PW-1:0]      pixel_x,
  output logic [stu_pkg::PW-1:0]      pixel_y,
  output logic                        visible,
  output stu_pkg::wb_t                wb
);

  localparam int NS = stu_pkg::DIV_STAGES;
  localparam int CW = stu_pkg::CW;
  localparam int ZW = stu_pkg::ZW;

  logic              v_r [NS+1];
  stu_pkg::job_t     p_r [NS+1];
  logic [CW-1:0]     nx_r [NS+1];
  logic [CW-1:0]     ny_r [NS+1];
  logic [ZW-1:0]     rx_r [NS+1];
  logic [ZW-1:0]     ry_r [NS+1];
  logic              en;

  logic signed [CW+1:0] qx, qy, px, py;
  logic                 off, vis;

  function automatic logic [ZW+CW-1:0] dstep(input logic [ZW-1:0] r, input logic [CW-1:0] n,
                                             input logic [ZW-1:0] d);
    logic [ZW:0]   t;
    logic [ZW-1:0] nr;
    logic          qb;
    t = {r, n[CW-1]};
    qb = (t >= {1'b0, d});
    nr = qb ? ZW'(t - {1'b0, d}) : t[ZW-1:0];
    return {nr, n[CW-2:0], qb};
  endfunction

  assign en = !out_valid || out_ready;
  assign job_ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= job;
      nx_r[0] <= job.x[CW-1] ? CW'(-job.x) : CW'(job.x);
      ny_r[0] <= job.y[CW-1] ? CW'(-job.y) : CW'(job.y);
      rx_r[0] <= '0;
      ry_r[0] <= '0;
      for (int s = 1; s <= NS; s++) begin
        p_r[s] <= p_r[s-1];
        {rx_r[s], nx_r[s]} <= dstep(rx_r[s-1], nx_r[s-1], p_r[s-1].z);
        {ry_r[s], ny_r[s]} <= dstep(ry_r[s-1], ny_r[s-1], p_r[s-1].z);
      end
      pixel_x <= vis ? px[stu_pkg::PW-1:0] : '0;
      pixel_y <= vis ? py[stu_pkg::PW-1:0] : '0;
      visible <= vis;
    end
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) begin
        v_r[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v_r[0] <= job_valid;
      for (int s = 1; s <= NS; s++) begin
        v_r[s] <= v_r[s-1];
      end
      out_valid <= v_r[NS];
    end
  end

  always_comb begin
    qx = p_r[NS].x[CW-1] ? -$signed({2'b00, nx_r[NS]}) : $signed({2'b00, nx_r[NS]});
    qy = p_r[NS].y[CW-1] ? -$signed({2'b00, ny_r[NS]}) : $signed({2'b00, ny_r[NS]});
    px = qx + $signed({7'b0, cfg.width[stu_pkg::PW-1:1]});
    py = qy + $signed({7'b0, cfg.height[stu_pkg::PW-1:1]});
    off = px[CW+1] || (px >= $signed({6'b0, cfg.width})) ||
          py[CW+1] || (py >= $signed({6'b0, cfg.height}));
    vis = !p_r[NS].oob && !off;
    wb.en = en && v_r[NS] && !p_r[NS].oob;
    wb.idx = p_r[NS].idx;
    wb.x = off ? p_r[NS].sx : p_r[NS].x;
    wb.y = off ? p_r[NS].sy : p_r[NS].y;
    wb.z = off ? ZW'(MAX_DEPTH) : p_r[NS].z;
  end

endmodule
`default_nettype wire

// ===== tb/tb_starfield_star_update.sv =====
`default_nettype none
module tb_starfield_star_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STARS = 256;
  localparam int FAR_DEPTH = 500;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        vis;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  starfield_star_update dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor state.
  shortint     star_x[STARS];
  shortint     star_y[STARS];
  int          star_z[STARS];
  logic [11:0] scr_w;
  logic [11:0] scr_h;
  logic        cw_dir;

  pixel_t pending_pixels[$];
  int     errors;
  int     sent_items;
  int     checked_pixels;
  int     shown_pixels;
  int     respawns;
  bit     quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_t project_star(input logic [7:0] idx, input shortint fx,
                                          input shortint fy, input logic [8:0] fd,
                                          input shortint sx, input shortint sy);
    pixel_t res;
    int x, y, z, px, py, d;
    res = '0;
    x = star_x[idx];
    y = star_y[idx];
    z = star_z[idx] - stu_pkg::SPEED;
    if (z <= 0) begin
      d = fd;
      if (d < 1) d = 1;
      if (d > FAR_DEPTH) d = FAR_DEPTH;
      z = (x != 0) ? FAR_DEPTH : d;
      x = fx;
      y = fy;
      respawns++;
    end else begin
      for (int k = 0; k < stu_pkg::ROT_STEPS; k++) begin
        if (!cw_dir) begin
          x = shortint'(x - (y >>> stu_pkg::ROT_SHIFT));
          y = shortint'(y + (x >>> stu_pkg::ROT_SHIFT));
        end else begin
          x = shortint'(x + (y >>> stu_pkg::ROT_SHIFT));
          y = shortint'(y - (x >>> stu_pkg::ROT_SHIFT));
        end
      end
    end
    px = x / z + int'(scr_w >> 1);
    py = y / z + int'(scr_h >> 1);
    if (px < 0 || px >= int'(scr_w) || py < 0 || py >= int'(scr_h)) begin
      x = sx;
      y = sy;
      z = FAR_DEPTH;
    end else begin
      res.px = px[11:0];
      res.py = py[11:0];
      res.vis = 1'b1;
    end
    star_x[idx] = shortint'(x);
    star_y[idx] = shortint'(y);
    star_z[idx] = z;
    return res;
  endfunction

  task automatic send_star(input logic [7:0] idx, input logic [15:0] fx, input logic [15:0] fy,
                           input logic [8:0] fd, input logic [15:0] sx, input logic [15:0] sy);
    int n;
    n = idle_gap();
    if (n > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, sy, sx, fd, fy, fx, idx};
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(project_star(idx, fx, fy, fd, sx, sy));
    sent_items++;
  endtask

  task automatic go_idle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      stu_pkg::CFG_WIDTH: scr_w = val;
      stu_pkg::CFG_HEIGHT: scr_h = val;
      stu_pkg::CFG_CLOCKWISE: cw_dir = val[0];
      default: ;
    endcase
  endtask

  task automatic set_screen(input logic [11:0] w, input logic [11:0] h, input logic dir);
    go_idle();
    write_reg(stu_pkg::CFG_WIDTH, w);
    write_reg(stu_pkg::CFG_HEIGHT, h);
    write_reg(stu_pkg::CFG_CLOCKWISE, {11'd0, dir});
  endtask

  task automatic random_star(input int pool);
    logic [7:0]  idx;
    logic [15:0] fx, fy, sx, sy;
    logic [8:0]  fd;
    int r;
    idx = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, pool - 1))
                                        : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 4) begin
      fx = 16'($urandom);
      fy = 16'($urandom);
    end else begin
      fx = 16'($signed($urandom_range(0, 2000)) - 1000);
      fy = 16'($signed($urandom_range(0, 2000)) - 1000);
    end
    r = $urandom_range(0, 19);
    if (r == 0) fd = 9'd0;
    else if (r == 1) fd = 9'($urandom_range(501, 511));
    else if (r < 8) fd = 9'($urandom_range(1, 12));
    else fd = 9'($urandom_range(1, 500));
    sx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
    sy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
    send_star(idx, fx, fy, fd, sx, sy);
  endtask

  // Stars fresh from reset respawn; covers depth saturation and field extremes.
  task automatic test_respawn_corners();
    quiet = 1'b1;
    send_star(8'd0, 16'h0000, 16'h0000, 9'd0, 16'h0000, 16'h0000);
    send_star(8'd255, 16'h7FFF, 16'h8000, 9'd511, 16'h0001, 16'hFFFF);
    send_star(8'd1, 16'h8000, 16'h7FFF, 9'd500, 16'h8000, 16'h7FFF);
    send_star(8'd2, 16'd100, 16'hFF9C, 9'd1, 16'h0000, 16'h0000);
    send_star(8'd3, 16'h0000, 16'd50, 9'd4, 16'hFFFF, 16'hFFFF);
    send_star(8'd3, 16'h5555, 16'hAAAA, 9'h155, 16'hAAAA, 16'h5555);
    send_star(8'd3, 16'd10, 16'd10, 9'h0AA, 16'h1234, 16'h4321);
    send_star(8'd2, 16'hAAAA, 16'h5555, 9'd7, 16'h7FFF, 16'h8000);
    quiet = 1'b0;
  endtask

  task automatic test_rotation_ccw();
    for (int i = 0; i < 8; i++)
      send_star(8'd0, 16'($urandom), 16'($urandom), 9'($urandom_range(1, 500)),
                16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 4000) - 2000));
  endtask

  task automatic test_rotation_cw();
    set_screen(12'd640, 12'd480, 1'b1);
    for (int i = 0; i < 6; i++) random_star(2);
  endtask

  task automatic test_screen_extremes();
    set_screen(12'd4095, 12'd4095, 1'b0);
    for (int i = 0; i < 3; i++) random_star(4);
    set_screen(12'd0, 12'd0, 1'b1);
    for (int i = 0; i < 3; i++) random_star(4);
  endtask

  task automatic test_random_traffic();
    logic [11:0] ws[6] = '{12'd640, 12'd1, 12'd4095, 12'd0, 12'd320, 12'd2048};
    logic [11:0] hs[6] = '{12'd480, 12'd1, 12'd4095, 12'd480, 12'd240, 12'd0};
    for (int p = 0; p < 8; p++) begin
      if (p < 6) set_screen(ws[p], hs[p], p[0]);
      else set_screen(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), p[0]);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 165; i++) random_star((p % 2) ? 4 : 16);
      quiet = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transfer: data %h visible %b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        checked_pixels++;
        if (want.vis) shown_pixels++;
        if (out_tdata[11:0] !== want.px) begin
          $error("pixel_x: expected %0d, got %0d", want.px, out_tdata[11:0]);
          errors++;
        end
        if (out_tdata[23:12] !== want.py) begin
          $error("pixel_y: expected %0d, got %0d", want.py, out_tdata[23:12]);
          errors++;
        end
        if (out_tuser !== want.vis) begin
          $error("visible: expected %b, got %b", want.vis, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    int hold, n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk) out_tready <= 1'b1;
      hold = $urandom_range(0, 10);
      repeat (hold) @(negedge clk);
      n = idle_gap();
      if (n > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d pixels outstanding", pending_pixels.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    sent_items = 0;
    checked_pixels = 0;
    shown_pixels = 0;
    respawns = 0;
    quiet = 1'b0;
    scr_w = 12'd640;
    scr_h = 12'd480;
    cw_dir = 1'b0;
    for (int i = 0; i < STARS; i++) begin
      star_x[i] = 0;
      star_y[i] = 0;
      star_z[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_respawn_corners();
    test_rotation_ccw();
    test_rotation_cw();
    test_screen_extremes();
    test_random_traffic();
    go_idle();

    $display("Sent %0d stars, checked %0d pixels, %0d drawn, %0d respawns from passing.",
             sent_items, checked_pixels, shown_pixels, respawns);
    $display("Screen sizes from 0 to 4095 were used with both rotation directions.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== starfield_star_update.f =====
sv/stu_pkg.sv
sv/stu_fifo.sv
sv/stu_front.sv
sv/stu_back.sv
sv/starfield_star_update.sv
tb/tb_starfield_star_update.sv
